// ===== design/life_3d_generation_step_unit_defines.svh =====
// ----------------------------------------------------------------------------
// life 3d generation step unit: assertion macros
// shared property wrappers, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef LIFE_3D_GENERATION_STEP_UNIT_DEFINES_SVH
`define LIFE_3D_GENERATION_STEP_UNIT_DEFINES_SVH

// same-cycle implication
`define L3D_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define L3D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/l3d_pkg.sv =====
// ----------------------------------------------------------------------------
// l3d_pkg
// opcodes, register indexes and defaults of the 3d life unit
// ----------------------------------------------------------------------------
package l3d_pkg;

  localparam int L3D_CELLS_PER_DIM = 16;
  localparam int L3D_COORD_W       = 4;
  localparam int L3D_CFG_IDX_W     = 3;
  localparam int L3D_CFG_DATA_W    = 5;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_UNUSED  = 2'd3
  } l3d_op_t;

  localparam logic [L3D_CFG_IDX_W-1:0] CFG_SURVIVE_LOW  = 3'd0;
  localparam logic [L3D_CFG_IDX_W-1:0] CFG_SURVIVE_HIGH = 3'd1;
  localparam logic [L3D_CFG_IDX_W-1:0] CFG_BIRTH_LOW    = 3'd2;
  localparam logic [L3D_CFG_IDX_W-1:0] CFG_BIRTH_HIGH   = 3'd3;

  localparam logic [L3D_CFG_DATA_W-1:0] RST_SURVIVE_LOW  = 5'd4;
  localparam logic [L3D_CFG_DATA_W-1:0] RST_SURVIVE_HIGH = 5'd5;
  localparam logic [L3D_CFG_DATA_W-1:0] RST_BIRTH_LOW    = 5'd5;
  localparam logic [L3D_CFG_DATA_W-1:0] RST_BIRTH_HIGH   = 5'd5;

endpackage

// ===== design/life_3d_generation_step_unit.sv =====
// ----------------------------------------------------------------------------
// life_3d_generation_step_unit: 3d game of life over a cube of one-bit cells
// write and unused-opcode items: result in the cycle after transfer
// read: via ST_READ and the output register; advance: one cell per cycle,
//   set by the single read port of the grid memory feeding the shift chain
// one item at a time; a new item is taken only when the result slot is empty
//   or its result leaves in that same cycle
// reset: synchronous active-low; a clearing pass over all N^3 cells zeroes both
//   grids, no item is taken during it (config writes are always taken)
// ----------------------------------------------------------------------------
module life_3d_generation_step_unit #(
  parameter int CELLS_PER_DIM = l3d_pkg::L3D_CELLS_PER_DIM
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_opcode,
  input  logic [l3d_pkg::L3D_COORD_W-1:0]    in_cell_x,
  input  logic [l3d_pkg::L3D_COORD_W-1:0]    in_cell_y,
  input  logic [l3d_pkg::L3D_COORD_W-1:0]    in_cell_z,
  input  logic                               in_write_alive,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_read_alive,
  output logic                               out_op_done,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [l3d_pkg::L3D_CFG_IDX_W-1:0]  cfg_index,
  input  logic [l3d_pkg::L3D_CFG_DATA_W-1:0] cfg_wdata
);

  import l3d_pkg::*;

  `include "life_3d_generation_step_unit_defines.svh"

  // geometry
  localparam int N          = CELLS_PER_DIM;
  localparam int TOTAL      = N * N * N;
  localparam int AW         = $clog2(TOTAL);
  localparam int CW         = $clog2(N);
  // the chain center lags the newest bit by one plane, one row and one cell
  localparam int LAG        = N * N + N + 1;
  localparam int CHAIN_LEN  = 2 * LAG + 1;
  localparam int SWEEP_LAST = TOTAL + LAG + 2;
  localparam int CNT_W      = $clog2(SWEEP_LAST + 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SWEEP
  } state_t;

  state_t state_r;

  logic [CNT_W-1:0] cnt_r;
  logic             even_cur_r;
  logic             rd_inside_r;
  logic             out_valid_r;
  logic             out_read_alive_r;
  logic             out_op_done_r;

  logic [L3D_CFG_DATA_W-1:0] survive_low_r;
  logic [L3D_CFG_DATA_W-1:0] survive_high_r;
  logic [L3D_CFG_DATA_W-1:0] birth_low_r;
  logic [L3D_CFG_DATA_W-1:0] birth_high_r;

  // evaluation and write-back stages of the sweep
  logic [CW-1:0] cx_r, cy_r, cz_r;
  logic [AW-1:0] ctr_idx_r;
  logic [4:0]    nb_cnt_r;
  logic          ctr_alive_r;
  logic [AW-1:0] widx_r;
  logic          w_valid_r;

  // ---------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------
  logic in_xfer;
  logic out_free;
  logic produce;
  logic prod_read_alive;
  logic prod_op_done;

  // output slot is free if empty or being taken this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) && out_free);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_read_alive = out_read_alive_r;
  assign out_op_done    = out_op_done_r;

  // ---------------------------------------------------------------------------
  // item address decode
  // ---------------------------------------------------------------------------
  logic          item_inside;
  logic [31:0]   item_lin;
  logic [AW-1:0] item_addr;

  assign item_inside = (32'(in_cell_x) < 32'(N)) && (32'(in_cell_y) < 32'(N)) &&
                       (32'(in_cell_z) < 32'(N));
  assign item_lin  = 32'(in_cell_z) * 32'(N * N) + 32'(in_cell_y) * 32'(N) +
                     32'(in_cell_x);
  assign item_addr = item_lin[AW-1:0];

  // ---------------------------------------------------------------------------
  // grid memories: the current grid takes item transfers, the other one the
  // new generation during a sweep
  // ---------------------------------------------------------------------------
  logic          we_even, we_odd;
  logic [AW-1:0] wa_even, wa_odd;
  logic          wd_even, wd_odd;
  logic [AW-1:0] rd_addr;
  logic          rdata_even, rdata_odd, rdata_cur;
  logic          new_live;
  logic          item_wr;

  assign item_wr = in_xfer && (l3d_op_t'(in_opcode) == OP_WRITE) && item_inside;
  assign rd_addr = (state_r == ST_SWEEP) ? cnt_r[AW-1:0] : item_addr;

  always_comb begin
    we_even = 1'b0;
    we_odd  = 1'b0;
    wa_even = item_addr;
    wa_odd  = item_addr;
    wd_even = in_write_alive;
    wd_odd  = in_write_alive;
    unique case (state_r)
      ST_CLEAR: begin
        we_even = 1'b1;
        we_odd  = 1'b1;
        wa_even = cnt_r[AW-1:0];
        wa_odd  = cnt_r[AW-1:0];
        wd_even = 1'b0;
        wd_odd  = 1'b0;
      end
      ST_IDLE: begin
        we_even = item_wr && even_cur_r;
        we_odd  = item_wr && !even_cur_r;
      end
      ST_SWEEP: begin
        // new generation goes to the grid that is not current
        we_even = w_valid_r && !even_cur_r;
        we_odd  = w_valid_r && even_cur_r;
        wa_even = widx_r;
        wa_odd  = widx_r;
        wd_even = new_live;
        wd_odd  = new_live;
      end
      default: begin
      end
    endcase
  end

  l3d_grid_mem #(.DEPTH(TOTAL), .AW(AW)) u_grid_even (
    .clk     (clk),
    .wr_en   (we_even),
    .wr_addr (wa_even),
    .wr_data (wd_even),
    .rd_addr (rd_addr),
    .rd_data (rdata_even)
  );

  l3d_grid_mem #(.DEPTH(TOTAL), .AW(AW)) u_grid_odd (
    .clk     (clk),
    .wr_en   (we_odd),
    .wr_addr (wa_odd),
    .wr_data (wd_odd),
    .rd_addr (rd_addr),
    .rd_data (rdata_odd)
  );

  assign rdata_cur = even_cur_r ? rdata_even : rdata_odd;

  // ---------------------------------------------------------------------------
  // neighborhood shift chain: cell 0 holds the newest streamed bit, the
  // center cell sits LAG places down, neighbors at fixed taps around it
  // ---------------------------------------------------------------------------
  logic chain_en;
  logic chain_q [CHAIN_LEN];

  assign chain_en = (state_r == ST_SWEEP);

  l3d_cell u_cell_head (
    .clk      (clk),
    .shift_en (chain_en),
    .bit_in   (rdata_cur),
    .bit_out  (chain_q[0])
  );

  for (genvar gi = 1; gi < CHAIN_LEN; gi++) begin : g_chain
    l3d_cell u_cell (
      .clk      (clk),
      .shift_en (chain_en),
      .bit_in   (chain_q[gi-1]),
      .bit_out  (chain_q[gi])
    );
  end

  // 3x3x3 window, index dz*9 + dy*3 + dx with offsets -1..1 stored as 0..2
  logic [26:0] win;

  for (genvar gz = 0; gz < 3; gz++) begin : g_wz
    for (genvar gy = 0; gy < 3; gy++) begin : g_wy
      for (genvar gx = 0; gx < 3; gx++) begin : g_wx
        assign win[gz*9 + gy*3 + gx] =
          chain_q[LAG - (gx - 1) - (gy - 1) * N - (gz - 1) * N * N];
      end
    end
  end

  // neighbors outside the cube count as dead; this also hides row wrap
  logic [2:0]  xok, yok, zok;
  logic [26:0] nb;
  logic [1:0]  row_sum   [9];
  logic [3:0]  plane_sum [3];
  logic [4:0]  nb_sum;

  assign xok = {cx_r != CW'(N - 1), 1'b1, cx_r != '0};
  assign yok = {cy_r != CW'(N - 1), 1'b1, cy_r != '0};
  assign zok = {cz_r != CW'(N - 1), 1'b1, cz_r != '0};

  always_comb begin
    for (int z = 0; z < 3; z++) begin
      for (int y = 0; y < 3; y++) begin
        for (int x = 0; x < 3; x++) begin
          nb[z*9 + y*3 + x] = win[z*9 + y*3 + x] && xok[x] && yok[y] && zok[z];
        end
      end
    end
    nb[13] = 1'b0;  // center cell is not its own neighbor
    for (int r = 0; r < 9; r++) begin
      row_sum[r] = 2'(nb[r*3]) + 2'(nb[r*3 + 1]) + 2'(nb[r*3 + 2]);
    end
    for (int p = 0; p < 3; p++) begin
      plane_sum[p] = 4'(row_sum[p*3]) + 4'(row_sum[p*3 + 1]) + 4'(row_sum[p*3 + 2]);
    end
    nb_sum = 5'(plane_sum[0]) + 5'(plane_sum[1]) + 5'(plane_sum[2]);
  end

  // rule check on the registered count
  assign new_live = ctr_alive_r ?
                    ((nb_cnt_r >= survive_low_r) && (nb_cnt_r <= survive_high_r)) :
                    ((nb_cnt_r >= birth_low_r) && (nb_cnt_r <= birth_high_r));

  // center is valid once the read stream is LAG + 2 cells ahead of it
  logic ev_valid;
  logic sweep_last;

  assign ev_valid   = (state_r == ST_SWEEP) && (cnt_r >= CNT_W'(LAG + 2)) &&
                      (cnt_r <= CNT_W'(TOTAL + LAG + 1));
  assign sweep_last = (cnt_r == CNT_W'(SWEEP_LAST));

  always_ff @(posedge clk) begin
    if (ev_valid) begin
      nb_cnt_r    <= nb_sum;
      ctr_alive_r <= chain_q[LAG];
      widx_r      <= ctr_idx_r;
    end
  end

  // ---------------------------------------------------------------------------
  // result selection
  // ---------------------------------------------------------------------------
  always_comb begin
    produce         = 1'b0;
    prod_read_alive = 1'b0;
    prod_op_done    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && (l3d_op_t'(in_opcode) == OP_WRITE)) begin
          produce      = 1'b1;
          prod_op_done = 1'b1;
        end else if (in_xfer && (l3d_op_t'(in_opcode) == OP_UNUSED)) begin
          produce = 1'b1;
        end
      end
      ST_READ: begin
        produce         = 1'b1;
        prod_read_alive = rd_inside_r && rdata_cur;
        prod_op_done    = 1'b1;
      end
      ST_SWEEP: begin
        produce      = sweep_last;
        prod_op_done = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // control: state, counters, output register and configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_CLEAR;
      cnt_r            <= '0;
      even_cur_r       <= 1'b1;
      rd_inside_r      <= 1'b0;
      out_valid_r      <= 1'b0;
      out_read_alive_r <= 1'b0;
      out_op_done_r    <= 1'b0;
      cx_r             <= '0;
      cy_r             <= '0;
      cz_r             <= '0;
      ctr_idx_r        <= '0;
      w_valid_r        <= 1'b0;
      survive_low_r    <= RST_SURVIVE_LOW;
      survive_high_r   <= RST_SURVIVE_HIGH;
      birth_low_r      <= RST_BIRTH_LOW;
      birth_high_r     <= RST_BIRTH_HIGH;
    end else begin
      // register writes, any time
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SURVIVE_LOW:  survive_low_r  <= cfg_wdata;
          CFG_SURVIVE_HIGH: survive_high_r <= cfg_wdata;
          CFG_BIRTH_LOW:    birth_low_r    <= cfg_wdata;
          CFG_BIRTH_HIGH:   birth_high_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end

      // output register: load a new result or drop the one just taken
      if (produce) begin
        out_valid_r      <= 1'b1;
        out_read_alive_r <= prod_read_alive;
        out_op_done_r    <= prod_op_done;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      w_valid_r <= ev_valid;

      unique case (state_r)
        ST_CLEAR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(TOTAL - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer && (l3d_op_t'(in_opcode) == OP_READ)) begin
            rd_inside_r <= item_inside;
            state_r     <= ST_READ;
          end else if (in_xfer && (l3d_op_t'(in_opcode) == OP_ADVANCE)) begin
            cnt_r     <= '0;
            cx_r      <= '0;
            cy_r      <= '0;
            cz_r      <= '0;
            ctr_idx_r <= '0;
            state_r   <= ST_SWEEP;
          end
        end
        ST_READ: begin
          state_r <= ST_IDLE;
        end
        ST_SWEEP: begin
          cnt_r <= cnt_r + 1'b1;
          if (ev_valid) begin
            ctr_idx_r <= ctr_idx_r + 1'b1;
            if (cx_r == CW'(N - 1)) begin
              cx_r <= '0;
              if (cy_r == CW'(N - 1)) begin
                cy_r <= '0;
                cz_r <= cz_r + 1'b1;
              end else begin
                cy_r <= cy_r + 1'b1;
              end
            end else begin
              cx_r <= cx_r + 1'b1;
            end
          end
          // last write-back lands on this edge, then the grids swap roles
          if (sweep_last) begin
            even_cur_r <= !even_cur_r;
            state_r    <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `L3D_ASSERT_NEXT(a_swap_after_sweep, (state_r == ST_SWEEP) && sweep_last, even_cur_r != $past(even_cur_r), "grids did not swap at end of sweep")
  `L3D_ASSERT_IMPL(a_wb_only_in_sweep, w_valid_r, state_r == ST_SWEEP, "write-back outside sweep")
  `L3D_ASSERT_IMPL(a_no_result_overrun, produce, !out_valid_r || !out_stall, "result overwrites a pending one")
  `L3D_ASSERT_IMPL(a_no_item_in_clear, state_r == ST_CLEAR, in_stall, "item taken during clearing pass")

endmodule

// ===== design/l3d_cell.sv =====
// ----------------------------------------------------------------------------
// l3d_cell
// one stage of the neighborhood shift chain, holds one grid bit
// ----------------------------------------------------------------------------
module l3d_cell (
  input  logic clk,
  input  logic shift_en,
  input  logic bit_in,
  output logic bit_out
);

  logic bit_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      bit_r <= bit_in;
    end
  end

  assign bit_out = bit_r;

endmodule

// ===== design/l3d_grid_mem.sv =====
// ----------------------------------------------------------------------------
// l3d_grid_mem
// one-bit grid store, one write port and one registered read port
// ----------------------------------------------------------------------------
module l3d_grid_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data
);

  logic mem [DEPTH];
  logic rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== bench/tb_life_3d_generation_step_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_life_3d_generation_step_unit
// drives cell writes, reads, generation advances and unused opcodes through
// the unit under several survival and birth ranges; a cycle-free cube model
// inside the bench predicts results not typed into a row, checked field by field
// ----------------------------------------------------------------------------
module tb_life_3d_generation_step_unit;
  import l3d_pkg::*;

  localparam int N         = L3D_CELLS_PER_DIM;
  localparam int CELLS     = N * N * N;
  localparam int HOLD_LEN  = 400;    // long receiver hold-off
  localparam int DOG_LIMIT = 40000;  // clearing pass + advance + stalls, with margin

  typedef struct {
    logic rd;
    logic done;
  } life_result_t;

  typedef struct {
    l3d_op_t    op;
    logic [3:0] x, y, z;
    logic       wv;
    bit         fixed;  // expectation typed into the row
    logic       rd, done;
  } life_row_t;

  typedef struct {
    bit   fixed;
    logic rd, done;
  } row_note_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_opcode;
  logic [3:0] in_cell_x, in_cell_y, in_cell_z;
  logic in_write_alive;
  logic out_valid, out_stall, out_read_alive, out_op_done;
  logic cfg_valid, cfg_ready;
  logic [L3D_CFG_IDX_W-1:0] cfg_index;
  logic [L3D_CFG_DATA_W-1:0] cfg_wdata;

  life_3d_generation_step_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_cell_x(in_cell_x), .in_cell_y(in_cell_y), .in_cell_z(in_cell_z),
    .in_write_alive(in_write_alive),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_read_alive(out_read_alive), .out_op_done(out_op_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // clock, 4 ns period
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // cube model: two grids that swap roles on every advance
  bit   cube [2][CELLS];
  bit   cur_sel;  // 0: even grid current
  logic [4:0] surv_lo, surv_hi, born_lo, born_hi;

  life_result_t expected_q[$];
  row_note_t    note_q[$];
  life_row_t    rows[$];

  int  failures, n_results, n_write, n_read, n_adv, n_unused, n_cfg, idle_cycles;
  bit  hold_req, quiet;

  function automatic int cell_at(int x, int y, int z);
    return (z * N + y) * N + x;
  endfunction

  function automatic int live_neighbours(int g, int x, int y, int z);
    int cnt;
    cnt = 0;
    for (int c = z - 1; c <= z + 1; c++)
      for (int b = y - 1; b <= y + 1; b++)
        for (int a = x - 1; a <= x + 1; a++)
          // outside the cube counts as dead, no wraparound
          if (a >= 0 && a < N && b >= 0 && b < N && c >= 0 && c < N &&
              !(a == x && b == y && c == z) && cube[g][cell_at(a, b, c)])
            cnt++;
    return cnt;
  endfunction

  task automatic step_generation();
    int cnt, i, src, dst;
    src = cur_sel;
    dst = !cur_sel;
    for (int z = 0; z < N; z++)
      for (int y = 0; y < N; y++)
        for (int x = 0; x < N; x++) begin
          cnt = live_neighbours(src, x, y, z);
          i = cell_at(x, y, z);
          if (cube[src][i]) cube[dst][i] = (cnt >= surv_lo && cnt <= surv_hi);
          else              cube[dst][i] = (cnt >= born_lo && cnt <= born_hi);
        end
    cur_sel = !cur_sel;
  endtask

  // applies one accepted item to the cube model and returns its result
  task automatic apply_cell_op(input l3d_op_t op, input int x, y, z, input bit wv,
                               output life_result_t r);
    r.rd = 1'b0;
    r.done = 1'b1;
    case (op)
      OP_WRITE: begin
        cube[cur_sel][cell_at(x, y, z)] = wv;
        n_write++;
      end
      OP_READ: begin
        r.rd = cube[cur_sel][cell_at(x, y, z)];
        n_read++;
      end
      OP_ADVANCE: begin
        step_generation();
        n_adv++;
      end
      default: begin
        r.done = 1'b0;
        n_unused++;
      end
    endcase
  endtask

  // watch all three channels at each edge: predict, check, count idle cycles
  always @(posedge clk) begin
    life_result_t r, e;
    row_note_t nt;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        n_cfg++;
        case (cfg_index)
          CFG_SURVIVE_LOW:  surv_lo = cfg_wdata;
          CFG_SURVIVE_HIGH: surv_hi = cfg_wdata;
          CFG_BIRTH_LOW:    born_lo = cfg_wdata;
          CFG_BIRTH_HIGH:   born_hi = cfg_wdata;
          default: ;  // index beyond the register file is dropped
        endcase
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        apply_cell_op(l3d_op_t'(in_opcode), in_cell_x, in_cell_y, in_cell_z,
                      in_write_alive, r);
        nt = note_q.pop_front();
        if (nt.fixed) begin
          r.rd = nt.rd;
          r.done = nt.done;
        end
        expected_q.push_back(r);
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        n_results++;
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected");
          failures++;
        end else begin
          e = expected_q.pop_front();
          if (out_read_alive !== e.rd) begin
            $error("read_alive: expected %0b, got %0b", e.rd, out_read_alive);
            failures++;
          end
          if (out_op_done !== e.done) begin
            $error("op_done: expected %0b, got %0b", e.done, out_op_done);
            failures++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (idle_cycles >= DOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", DOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (quiet || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random stall, or one long hold-off when asked
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  task automatic send_item(input life_row_t it);
    int n;
    row_note_t nt;
    nt.fixed = it.fixed;
    nt.rd = it.rd;
    nt.done = it.done;
    note_q.push_back(nt);
    in_valid       <= 1'b1;
    in_opcode      <= it.op;
    in_cell_x      <= it.x;
    in_cell_y      <= it.y;
    in_cell_z      <= it.z;
    in_write_alive <= it.wv;
    do @(posedge clk); while (in_stall);
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [L3D_CFG_IDX_W-1:0] idx,
                           input logic [L3D_CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_rule(input logic [4:0] sl, sh, bl, bh);
    write_reg(CFG_SURVIVE_LOW, sl);
    write_reg(CFG_SURVIVE_HIGH, sh);
    write_reg(CFG_BIRTH_LOW, bl);
    write_reg(CFG_BIRTH_HIGH, bh);
  endtask

  // wait until every expected result has come back, then let the unit settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic life_row_t mk(l3d_op_t op, int x, y, z, bit wv);
    life_row_t it;
    it.op = op;
    it.x = 4'(x);
    it.y = 4'(y);
    it.z = 4'(z);
    it.wv = wv;
    it.fixed = 1'b0;
    it.rd = 1'b0;
    it.done = 1'b0;
    return it;
  endfunction

  function automatic life_row_t mk_fixed(l3d_op_t op, int x, y, z, bit wv, bit rd, done);
    life_row_t it;
    it = mk(op, x, y, z, wv);
    it.fixed = 1'b1;
    it.rd = rd;
    it.done = done;
    return it;
  endfunction

  // random item: cells mostly in a small cluster so generations stay lively
  function automatic life_row_t rand_item();
    int p, x, y, z;
    l3d_op_t op;
    p = $urandom_range(99);
    if (p < 45)      op = OP_WRITE;
    else if (p < 82) op = OP_READ;
    else if (p < 90) op = OP_ADVANCE;
    else             op = OP_UNUSED;
    if ($urandom_range(99) < 65) begin
      x = $urandom_range(5, 9);
      y = $urandom_range(5, 9);
      z = $urandom_range(5, 9);
    end else begin
      x = $urandom_range(15);
      y = $urandom_range(15);
      z = $urandom_range(15);
    end
    return mk(op, x, y, z, $urandom_range(99) < 70);
  endfunction

  task automatic random_phase(input int count);
    repeat (count) send_item(rand_item());
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_WRITE;
    in_cell_x = '0;
    in_cell_y = '0;
    in_cell_z = '0;
    in_write_alive = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    hold_req = 1'b0;
    quiet = 1'b0;
    failures = 0;
    n_results = 0;
    n_write = 0;
    n_read = 0;
    n_adv = 0;
    n_unused = 0;
    n_cfg = 0;
    idle_cycles = 0;
    cur_sel = 1'b0;
    surv_lo = RST_SURVIVE_LOW;
    surv_hi = RST_SURVIVE_HIGH;
    born_lo = RST_BIRTH_LOW;
    born_hi = RST_BIRTH_HIGH;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows: reset state, corners, unused opcode, a small cluster
    rows.push_back(mk_fixed(OP_READ, 0, 0, 0, 1'b0, 1'b0, 1'b1));
    rows.push_back(mk_fixed(OP_READ, 15, 15, 15, 1'b1, 1'b0, 1'b1));
    rows.push_back(mk_fixed(OP_WRITE, 15, 15, 15, 1'b1, 1'b0, 1'b1));
    rows.push_back(mk_fixed(OP_WRITE, 0, 0, 0, 1'b1, 1'b0, 1'b1));
    rows.push_back(mk_fixed(OP_READ, 15, 15, 15, 1'b0, 1'b1, 1'b1));
    rows.push_back(mk_fixed(OP_READ, 0, 0, 0, 1'b0, 1'b1, 1'b1));
    rows.push_back(mk_fixed(OP_UNUSED, 15, 15, 15, 1'b1, 1'b0, 1'b0));
    rows.push_back(mk_fixed(OP_UNUSED, 0, 0, 0, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk(OP_WRITE, 7, 7, 7, 1'b1));
    rows.push_back(mk(OP_WRITE, 8, 7, 7, 1'b1));
    rows.push_back(mk(OP_WRITE, 7, 8, 7, 1'b1));
    rows.push_back(mk(OP_WRITE, 7, 7, 8, 1'b1));
    rows.push_back(mk(OP_WRITE, 8, 8, 8, 1'b1));
    rows.push_back(mk(OP_WRITE, 0, 0, 0, 1'b0));
    rows.push_back(mk(OP_ADVANCE, 3, 12, 5, 1'b1));
    rows.push_back(mk(OP_READ, 8, 8, 7, 1'b0));
    rows.push_back(mk(OP_READ, 7, 7, 7, 1'b0));
    rows.push_back(mk(OP_READ, 15, 15, 15, 1'b1));
    rows.push_back(mk(OP_ADVANCE, 0, 0, 0, 1'b0));
    rows.push_back(mk(OP_READ, 8, 8, 8, 1'b1));
    rows.push_back(mk(OP_READ, 10, 5, 10, 1'b0));
    foreach (rows[i]) send_item(rows[i]);
    drain();

    // reset rule, random traffic
    random_phase(30);

    // wide survival, birth only at the top count; no idling at all
    quiet = 1'b1;
    set_rule(5'd0, 5'd26, 5'd26, 5'd26);
    random_phase(30);
    quiet = 1'b0;

    // empty survival range, birth at zero neighbours; two out-of-range indexes
    write_reg(3'd5, 5'd17);
    write_reg(3'd7, 5'd0);
    set_rule(5'd31, 5'd0, 5'd0, 5'd0);
    random_phase(25);

    // receiver holds off while items keep coming, filling the unit
    set_rule(5'd2, 5'd7, 5'd3, 5'd4);
    hold_req = 1'b1;
    random_phase(30);

    // top register values, both ranges empty of reachable counts
    set_rule(5'd31, 5'd31, 5'd27, 5'd31);
    random_phase(10);

    repeat (20) @(posedge clk);
    $display("covered %0d writes, %0d reads, %0d advances, %0d unused opcodes",
             n_write, n_read, n_adv, n_unused);
    $display("%0d results checked, %0d register writes, five rule settings",
             n_results, n_cfg);
    if (failures == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/l3d_pkg.sv
design/l3d_cell.sv
design/l3d_grid_mem.sv
design/life_3d_generation_step_unit.sv
bench/tb_life_3d_generation_step_unit.sv
